### src/cdlb_pkg.sv
package cdlb_pkg;

	localparam logic [2:0] FUNC_PUSH     = 3'd0;
	localparam logic [2:0] FUNC_DLY_READ = 3'd1;
	localparam logic [2:0] FUNC_DLY_MOD  = 3'd2;
	localparam logic [2:0] FUNC_PULL     = 3'd3;
	localparam logic [2:0] FUNC_PULL_ADD = 3'd4;

	localparam logic signed [23:0] S24_MAX = 24'sh7FFFFF;
	localparam logic signed [23:0] S24_MIN = 24'sh800000;

	typedef struct packed {
		logic [2:0]         func;
		logic signed [23:0] sample_in;
		logic [9:0]         delay;
		logic [9:0]         block_index;
		logic signed [23:0] factor;
		logic signed [23:0] addend;
	} cdlb_in_t;

	typedef struct packed {
		logic signed [23:0] sample_out;
		logic [9:0]         fill_level;
	} cdlb_out_t;

	typedef struct packed {
		logic clear_en;
		logic load;
		logic mem_rd;
		logic mul_en;
		logic finish;
	} cdlb_cmd_t;

	typedef struct packed {
		logic clear_last;
	} cdlb_stat_t;

endpackage

### src/cdlb_ctrl.sv
module cdlb_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	output logic               out_valid,
	input  logic               out_ready,
	output cdlb_pkg::cdlb_cmd_t cmd,
	input  cdlb_pkg::cdlb_stat_t stat
);

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_READ,
		ST_MUL,
		ST_WRITE
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   out_space;

	assign out_space = !out_valid_q || out_ready;

	assign cmd.clear_en = (state_q == ST_CLEAR);
	assign cmd.load     = (state_q == ST_IDLE) && in_valid;
	assign cmd.mem_rd   = (state_q == ST_READ);
	assign cmd.mul_en   = (state_q == ST_MUL);
	assign cmd.finish   = (state_q == ST_WRITE) && out_space;

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_CLEAR: begin
					if (stat.clear_last) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_READ;
					end
				end
				ST_READ: begin
					state_q <= ST_MUL;
				end
				ST_MUL: begin
					state_q <= ST_WRITE;
				end
				ST_WRITE: begin
					if (out_space) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_CLEAR;
				end
			endcase
			if (cmd.finish) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

### src/cdlb_datapath.sv
module cdlb_datapath #(
	parameter int DEPTH = 1024
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  cdlb_pkg::cdlb_cmd_t  cmd,
	output cdlb_pkg::cdlb_stat_t stat,
	input  cdlb_pkg::cdlb_in_t   in_data,
	output cdlb_pkg::cdlb_out_t  out_data
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic signed [23:0] mem [DEPTH];

	cdlb_pkg::cdlb_in_t  item_q;
	cdlb_pkg::cdlb_out_t out_q;
	logic [AW-1:0]       wp_q;
	logic [AW-1:0]       rp_q;
	logic [AW-1:0]       addr_q;
	logic [AW-1:0]       clr_q;
	logic signed [23:0]  rdata_q;
	logic signed [47:0]  prod_q;

	logic [AW-1:0]       wp_next;
	logic [AW-1:0]       rp_next;
	logic [AW-1:0]       addr_next;
	logic [AW+9:0]       tap_wide;
	logic [AW+9:0]       fill_wide;
	logic signed [48:0]  rnd;
	logic signed [25:0]  shifted;
	logic signed [23:0]  mod_res;
	logic signed [24:0]  sum25;
	logic signed [23:0]  add_res;
	logic signed [23:0]  result;
	logic                mem_we;
	logic [AW-1:0]       mem_waddr;
	logic signed [23:0]  mem_wdata;

	assign tap_wide = {10'd0, wp_q} - {{AW{1'b0}}, in_data.delay}
		+ {{AW{1'b0}}, in_data.block_index};

	always_comb begin
		wp_next   = wp_q;
		rp_next   = rp_q;
		addr_next = tap_wide[AW-1:0];
		unique case (in_data.func)
			cdlb_pkg::FUNC_PUSH: begin
				wp_next   = wp_q + AW'(1);
				addr_next = wp_q + AW'(1);
			end
			cdlb_pkg::FUNC_PULL, cdlb_pkg::FUNC_PULL_ADD: begin
				rp_next   = rp_q + AW'(1);
				addr_next = rp_q + AW'(1);
			end
			default: begin
				addr_next = tap_wide[AW-1:0];
			end
		endcase
	end

	assign rnd     = {prod_q[47], prod_q} + 49'sd4194304;
	assign shifted = rnd[48:23];
	assign mod_res = (shifted > 26'sd8388607) ? cdlb_pkg::S24_MAX :
		(shifted < -26'sd8388608) ? cdlb_pkg::S24_MIN : shifted[23:0];

	assign sum25   = {rdata_q[23], rdata_q} + {item_q.addend[23], item_q.addend};
	assign add_res = (sum25 > 25'sd8388607) ? cdlb_pkg::S24_MAX :
		(sum25 < -25'sd8388608) ? cdlb_pkg::S24_MIN : sum25[23:0];

	always_comb begin
		unique case (item_q.func)
			cdlb_pkg::FUNC_DLY_READ: result = rdata_q;
			cdlb_pkg::FUNC_DLY_MOD:  result = mod_res;
			cdlb_pkg::FUNC_PULL:     result = rdata_q;
			cdlb_pkg::FUNC_PULL_ADD: result = add_res;
			default:                 result = '0;
		endcase
	end

	assign fill_wide = {10'd0, wp_q - rp_q};

	assign mem_we = cmd.clear_en || (cmd.finish &&
		((item_q.func == cdlb_pkg::FUNC_PUSH) || (item_q.func == cdlb_pkg::FUNC_DLY_MOD)));
	assign mem_waddr = cmd.clear_en ? clr_q : addr_q;
	assign mem_wdata = cmd.clear_en ? 24'sd0 :
		(item_q.func == cdlb_pkg::FUNC_PUSH) ? item_q.sample_in : mod_res;

	assign stat.clear_last = (clr_q == AW'(DEPTH - 1));

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (cmd.mem_rd) begin
			rdata_q <= mem[addr_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			clr_q <= '0;
		end else begin
			if (cmd.clear_en) begin
				clr_q <= clr_q + AW'(1);
			end
			if (cmd.load) begin
				wp_q <= wp_next;
				rp_q <= rp_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			item_q <= in_data;
			addr_q <= addr_next;
		end
		if (cmd.mul_en) begin
			prod_q <= rdata_q * item_q.factor;
		end
		if (cmd.finish) begin
			out_q.sample_out <= result;
			out_q.fill_level <= fill_wide[9:0];
		end
	end

	assign out_data = out_q;

endmodule

### src/circular_delay_line_buffer_unit.sv
// Channel  Handshake              Word
// input    in_valid / in_ready    in_data  (cdlb_pkg::cdlb_in_t)
// output   out_valid / out_ready  out_data (cdlb_pkg::cdlb_out_t)
//
// Each word goes through these steps in order: address at acceptance, memory read, multiply,
// then round, saturate and write back through the single memory port, where the result is
// loaded into the output register; the next word can be accepted once that step is done.
// After reset every entry of the store is swept to zero while in_ready stays low.
// A finished result waits in the output register; the next word is accepted meanwhile.
// If that register is still full when the next result is ready, the block holds it.
module circular_delay_line_buffer_unit #(
	parameter int DEPTH = 1024
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  cdlb_pkg::cdlb_in_t  in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output cdlb_pkg::cdlb_out_t out_data
);

	cdlb_pkg::cdlb_cmd_t  cmd;
	cdlb_pkg::cdlb_stat_t stat;

	cdlb_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd),
		.stat      (stat)
	);

	cdlb_datapath #(
		.DEPTH (DEPTH)
	) u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.stat     (stat),
		.in_data  (in_data),
		.out_data (out_data)
	);

endmodule

### src/cdlb_checker.sv
module cdlb_checker #(
	parameter int DEPTH = 1024
) (
	input logic                clk,
	input logic                arst_n,
	input logic                in_valid,
	input logic                in_ready,
	input cdlb_pkg::cdlb_in_t  in_data,
	input logic                out_valid,
	input logic                out_ready,
	input cdlb_pkg::cdlb_out_t out_data
);

	// One word is worked on at a time.
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("input taken while a word is in progress");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
		else $error("stalled output word changed");

	// A new result only appears at the end of work, while input is blocked.
	a_out_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(!in_ready))
		else $error("output word without work in progress");

	a_fill_range: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (DEPTH < 1024)) |-> (int'(out_data.fill_level) < DEPTH))
		else $error("fill level beyond depth");

endmodule

bind circular_delay_line_buffer_unit cdlb_checker #(.DEPTH(DEPTH)) u_cdlb_checker (.*);

### tb/sv/cdlb_ring_checker.sv
`timescale 1ns / 1ps

module cdlb_ring_checker #(
	parameter int DEPTH = 1024
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                in_ready,
	input  cdlb_pkg::cdlb_in_t  in_data,
	input  logic                out_valid,
	input  logic                out_ready,
	input  cdlb_pkg::cdlb_out_t out_data,
	output int                  fail_count,
	output int                  pending
);
	import cdlb_pkg::*;

	localparam int AW = $clog2(DEPTH);

	logic signed [23:0] ring_mem [DEPTH];
	logic [AW-1:0]      head_pos;
	logic [AW-1:0]      tail_pos;
	cdlb_out_t          due_outputs [$];
	int                 bad_words;

	function automatic logic signed [23:0] clamp_s24(input longint v);
		if (v > longint'(S24_MAX))
			return S24_MAX;
		if (v < longint'(S24_MIN))
			return S24_MIN;
		return v[23:0];
	endfunction

	function automatic cdlb_out_t apply_ring_op(input cdlb_in_t w);
		cdlb_out_t     r;
		logic [AW-1:0] tap;
		longint        acc;
		r = '0;
		tap = head_pos - AW'(w.delay) + AW'(w.block_index);
		case (w.func)
			FUNC_PUSH: begin
				head_pos = head_pos + 1'b1;
				ring_mem[head_pos] = w.sample_in;
			end
			FUNC_DLY_READ: begin
				r.sample_out = ring_mem[tap];
			end
			FUNC_DLY_MOD: begin
				acc = longint'(ring_mem[tap]) * longint'(w.factor) + (longint'(1) <<< 22);
				r.sample_out = clamp_s24(acc >>> 23);
				ring_mem[tap] = r.sample_out;
			end
			FUNC_PULL: begin
				tail_pos = tail_pos + 1'b1;
				r.sample_out = ring_mem[tail_pos];
			end
			FUNC_PULL_ADD: begin
				tail_pos = tail_pos + 1'b1;
				r.sample_out = clamp_s24(longint'(ring_mem[tail_pos]) + longint'(w.addend));
			end
			default: begin
			end
		endcase
		r.fill_level = 10'(AW'(head_pos - tail_pos));
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		cdlb_out_t want;
		if (!arst_n) begin
			for (int i = 0; i < DEPTH; i++)
				ring_mem[i] = '0;
			head_pos = '0;
			tail_pos = '0;
			due_outputs.delete();
			bad_words = 0;
			fail_count <= 0;
			pending <= 0;
		end else begin
			if (out_valid && out_ready) begin
				if (due_outputs.size() == 0) begin
					bad_words++;
					if (bad_words <= 10)
						$display("%0t: unexpected output word sample_out=%0d fill_level=%0d",
							$time, out_data.sample_out, out_data.fill_level);
				end else begin
					want = due_outputs.pop_front();
					if (want.sample_out !== out_data.sample_out ||
							want.fill_level !== out_data.fill_level) begin
						bad_words++;
						if (bad_words <= 10)
							$display("%0t: sample_out exp %0d got %0d, fill_level exp %0d got %0d",
								$time, want.sample_out, out_data.sample_out,
								want.fill_level, out_data.fill_level);
					end
				end
			end
			if (in_valid && in_ready)
				due_outputs.push_back(apply_ring_op(in_data));
			fail_count <= bad_words;
			pending <= due_outputs.size();
		end
	end

endmodule

### tb/sv/tb_circular_delay_line_buffer_unit.sv
`timescale 1ns / 1ps

module tb_circular_delay_line_buffer_unit;
	import cdlb_pkg::*;

	localparam int          RING_DEPTH   = 1024;
	localparam int          RANDOM_WORDS = 450;
	localparam int          CYCLE_LIMIT  = 200000;
	localparam logic [2:0]  FUNC_SPARE_FIRST = 3'd5;
	localparam logic [2:0]  FUNC_SPARE_MID   = 3'd6;
	localparam logic [2:0]  FUNC_SPARE_LAST  = 3'd7;

	typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_SPARSE} rx_mode_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	cdlb_in_t   in_data = '0;
	logic       out_valid;
	logic       out_ready = 1'b0;
	cdlb_out_t  out_data;
	int         fail_count;
	int         pending;
	int         cycle_count = 0;
	int         burst_left = 0;
	rx_mode_t   rx_mode = RX_OPEN;
	int         rx_left = 0;
	logic [1:0] rx_beat = '0;

	circular_delay_line_buffer_unit #(
		.DEPTH(RING_DEPTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data)
	);

	cdlb_ring_checker #(
		.DEPTH(RING_DEPTH)
	) checker_i (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data),
		.fail_count(fail_count),
		.pending(pending)
	);

	always #1 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (rx_left == 0) begin
			rx_mode <= rx_mode_t'($urandom_range(2, 0));
			rx_left <= $urandom_range(200, 20);
		end else begin
			rx_left <= rx_left - 1;
		end
		case (rx_mode)
			RX_OPEN:  out_ready <= 1'b1;
			RX_COIN:  out_ready <= 1'($urandom_range(1, 0));
			default:  out_ready <= (rx_beat == 2'd0);
		endcase
		rx_beat <= rx_beat + 1'b1;
	end

	function automatic cdlb_in_t make_word(input logic [2:0] func, input logic signed [23:0] smp,
			input logic [9:0] dly, input logic [9:0] idx, input logic signed [23:0] fac,
			input logic signed [23:0] add);
		cdlb_in_t w;
		w.func = func;
		w.sample_in = smp;
		w.delay = dly;
		w.block_index = idx;
		w.factor = fac;
		w.addend = add;
		return w;
	endfunction

	function automatic logic signed [23:0] pick_s24();
		int roll;
		roll = $urandom_range(9, 0);
		if (roll == 0)
			return S24_MAX;
		if (roll == 1)
			return S24_MIN;
		return 24'($urandom);
	endfunction

	function automatic cdlb_in_t random_word();
		cdlb_in_t w;
		int       roll;
		w.sample_in = pick_s24();
		w.factor = pick_s24();
		w.addend = pick_s24();
		w.delay = ($urandom_range(9, 0) < 7) ? 10'($urandom_range(8, 0)) : 10'($urandom);
		w.block_index = ($urandom_range(9, 0) < 7) ? 10'($urandom_range(3, 0)) : 10'($urandom);
		roll = $urandom_range(99, 0);
		if (roll < 30)
			w.func = FUNC_PUSH;
		else if (roll < 50)
			w.func = FUNC_DLY_READ;
		else if (roll < 65)
			w.func = FUNC_DLY_MOD;
		else if (roll < 80)
			w.func = FUNC_PULL;
		else if (roll < 95)
			w.func = FUNC_PULL_ADD;
		else
			w.func = 3'($urandom_range(FUNC_SPARE_LAST, FUNC_SPARE_FIRST));
		return w;
	endfunction

	task automatic send_word(input cdlb_in_t w);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(30, 1);
			gap = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(12, 1);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		in_data <= w;
		in_valid <= 1'b1;
		do @(posedge clk); while (!in_ready);
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		send_word(make_word(FUNC_PUSH, S24_MAX, 10'd0, 10'd0, 24'sd0, 24'sd0));
		send_word(make_word(FUNC_PUSH, S24_MIN, 10'd0, 10'd0, 24'sd0, 24'sd0));
		send_word(make_word(FUNC_PUSH, 24'sd1, 10'd0, 10'd0, 24'sd0, 24'sd0));
		send_word(make_word(FUNC_DLY_READ, 24'sd0, 10'd0, 10'd0, 24'sd0, 24'sd0));
		send_word(make_word(FUNC_DLY_READ, 24'sd0, 10'd1, 10'd0, 24'sd0, 24'sd0));
		send_word(make_word(FUNC_DLY_READ, 24'sd0, 10'd1023, 10'd0, 24'sd0, 24'sd0));
		send_word(make_word(FUNC_DLY_READ, 24'sd0, 10'd0, 10'd1023, 24'sd0, 24'sd0));
		send_word(make_word(FUNC_DLY_READ, 24'sd0, 10'd1023, 10'd1023, 24'sd0, 24'sd0));
		send_word(make_word(FUNC_DLY_MOD, 24'sd0, 10'd1, 10'd0, S24_MIN, 24'sd0));
		send_word(make_word(FUNC_DLY_MOD, 24'sd0, 10'd2, 10'd0, S24_MAX, 24'sd0));
		send_word(make_word(FUNC_DLY_MOD, 24'sd0, 10'd0, 10'd0, 24'sh400000, 24'sd0));
		send_word(make_word(FUNC_DLY_MOD, 24'sd0, 10'd0, 10'd0, 24'shC00000, 24'sd0));
		send_word(make_word(FUNC_PULL, 24'sd0, 10'd0, 10'd0, 24'sd0, 24'sd0));
		send_word(make_word(FUNC_PULL_ADD, 24'sd0, 10'd0, 10'd0, 24'sd0, S24_MAX));
		send_word(make_word(FUNC_PUSH, S24_MIN, 10'd0, 10'd0, 24'sd0, 24'sd0));
		send_word(make_word(FUNC_PULL_ADD, 24'sd0, 10'd0, 10'd0, 24'sd0, S24_MIN));
		send_word(make_word(FUNC_PULL_ADD, 24'sd0, 10'd0, 10'd0, 24'sd0, S24_MIN));
		send_word(make_word(FUNC_PULL, 24'sd0, 10'd0, 10'd0, 24'sd0, 24'sd0));
		send_word(make_word(FUNC_SPARE_FIRST, S24_MAX, 10'd3, 10'd1, S24_MIN, S24_MAX));
		send_word(make_word(FUNC_SPARE_MID, 24'sd0, 10'd0, 10'd0, 24'sd0, 24'sd0));
		send_word(make_word(FUNC_SPARE_LAST, S24_MIN, 10'd1023, 10'd1023, S24_MAX, S24_MIN));

		for (int n = 0; n < RANDOM_WORDS; n++)
			send_word(random_word());
		in_valid <= 1'b0;

		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (16) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
